// ===== hdl/fed_pkg.sv =====
// Shared types, register map and constants of the feedback echo delay unit.
package fed_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned UNITY      = 32768;
  localparam int unsigned FRAC_BITS  = 15;
  localparam int unsigned MID_DEPTH  = 4;
  localparam int unsigned OUT_DEPTH  = 4;
  localparam int unsigned OUT_CNT_W  = $clog2(OUT_DEPTH + 1);
  localparam int unsigned APB_AW     = 5;
  localparam int unsigned APB_DW     = 32;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_SEEK   = 1'b1;

  localparam logic [1:0]        RST_CHANNEL_COUNT = 2'd1;
  localparam logic [12:0]       RST_DELAY_FRAMES  = 13'd4096;
  localparam logic [GAIN_W-1:0] RST_FEEDBACK_GAIN = 16'd16384;
  localparam logic [GAIN_W-1:0] RST_MIX_GAIN      = 16'd16384;
  localparam logic              RST_CLEAR_ON_SEEK = 1'b1;

  typedef enum logic [2:0] {
    REG_CHANNEL_COUNT = 3'd0,
    REG_DELAY_FRAMES  = 3'd1,
    REG_FEEDBACK_GAIN = 3'd2,
    REG_MIX_GAIN      = 3'd3,
    REG_CLEAR_ON_SEEK = 3'd4
  } reg_idx_e;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_CLEAR  = 1'b1
  } op_e;

  typedef enum logic {
    BK_CLEAR = 1'b0,
    BK_RUN   = 1'b1
  } back_state_e;

  typedef struct packed {
    logic                       cmd;
    logic signed [SAMPLE_W-1:0] in_sample;
    logic                       stream_end;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_sample;
    logic                       stream_end_res;
  } out_item_t;

  typedef struct packed {
    logic [1:0]        channel_count;
    logic [12:0]       delay_frames;
    logic [GAIN_W-1:0] feedback_gain;
    logic [GAIN_W-1:0] mix_gain;
    logic              clear_on_seek;
  } cfg_t;

endpackage

// ===== hdl/fed_regs.sv =====
// APB configuration registers of the feedback echo delay unit.
module fed_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fed_pkg::APB_AW-1:0]   paddr,
  input  logic [fed_pkg::APB_DW-1:0]   pwdata,
  output logic [fed_pkg::APB_DW-1:0]   prdata,
  output logic                         pready,
  output fed_pkg::cfg_t                cfg_o
);

  fed_pkg::cfg_t     cfg_q, cfg_d;
  fed_pkg::reg_idx_e idx;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = fed_pkg::reg_idx_e'(paddr[fed_pkg::APB_AW-1:2]);
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        fed_pkg::REG_CHANNEL_COUNT: cfg_d.channel_count = pwdata[1:0];
        fed_pkg::REG_DELAY_FRAMES:  cfg_d.delay_frames  = pwdata[12:0];
        fed_pkg::REG_FEEDBACK_GAIN: cfg_d.feedback_gain = pwdata[fed_pkg::GAIN_W-1:0];
        fed_pkg::REG_MIX_GAIN:      cfg_d.mix_gain      = pwdata[fed_pkg::GAIN_W-1:0];
        fed_pkg::REG_CLEAR_ON_SEEK: cfg_d.clear_on_seek = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      fed_pkg::REG_CHANNEL_COUNT: prdata = fed_pkg::APB_DW'(cfg_q.channel_count);
      fed_pkg::REG_DELAY_FRAMES:  prdata = fed_pkg::APB_DW'(cfg_q.delay_frames);
      fed_pkg::REG_FEEDBACK_GAIN: prdata = fed_pkg::APB_DW'(cfg_q.feedback_gain);
      fed_pkg::REG_MIX_GAIN:      prdata = fed_pkg::APB_DW'(cfg_q.mix_gain);
      fed_pkg::REG_CLEAR_ON_SEEK: prdata = fed_pkg::APB_DW'(cfg_q.clear_on_seek);
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.channel_count <= fed_pkg::RST_CHANNEL_COUNT;
      cfg_q.delay_frames  <= fed_pkg::RST_DELAY_FRAMES;
      cfg_q.feedback_gain <= fed_pkg::RST_FEEDBACK_GAIN;
      cfg_q.mix_gain      <= fed_pkg::RST_MIX_GAIN;
      cfg_q.clear_on_seek <= fed_pkg::RST_CLEAR_ON_SEEK;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== hdl/fed_fifo.sv =====
// Small register FIFO used between the front, the back and the result port.
module fed_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o,
  output logic [CNT_W-1:0] count_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== hdl/fed_front.sv =====
// Front end: takes items, classifies them and tracks the store position.
module fed_front #(
  parameter int unsigned MAX_DELAY_FRAMES = 4096,
  parameter int unsigned MAX_CHANNELS     = 2,
  localparam int unsigned DEPTH  = MAX_DELAY_FRAMES * MAX_CHANNELS,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  fed_pkg::cfg_t                     cfg_i,
  input  logic                              push_i,
  input  fed_pkg::in_item_t                 in_data_i,
  output logic                              full_o,
  input  logic                              hold_i,
  input  logic                              mid_full_i,
  output logic                              mid_push_o,
  output fed_pkg::op_e                      mid_op_o,
  output logic [ADDR_W-1:0]                 mid_addr_o,
  output logic signed [fed_pkg::SAMPLE_W-1:0] mid_sample_o,
  output logic                              mid_end_o
);

  localparam int unsigned FW  = (MAX_DELAY_FRAMES > 1) ? $clog2(MAX_DELAY_FRAMES) : 1;
  localparam int unsigned CW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned DLW = FW + 1;
  localparam int unsigned CHW = CW + 1;

  logic [FW-1:0]  wf_q, wf_d, wf_eff;
  logic [CW-1:0]  ci_q, ci_d, ci_eff;
  logic [DLW-1:0] dl_eff, wf_inc;
  logic [CHW-1:0] ch_eff, ci_inc;
  logic           accept, is_seek;

  assign full_o  = mid_full_i || hold_i;
  assign accept  = push_i && !full_o;
  assign is_seek = (in_data_i.cmd == fed_pkg::CMD_SEEK);

  // Clamp the configured geometry to what the store holds.
  always_comb begin
    if (cfg_i.channel_count == '0) begin
      ch_eff = CHW'(1);
    end else if (32'(cfg_i.channel_count) > MAX_CHANNELS) begin
      ch_eff = CHW'(MAX_CHANNELS);
    end else begin
      ch_eff = CHW'(cfg_i.channel_count);
    end
    if (cfg_i.delay_frames == '0) begin
      dl_eff = DLW'(1);
    end else if (32'(cfg_i.delay_frames) > MAX_DELAY_FRAMES) begin
      dl_eff = DLW'(MAX_DELAY_FRAMES);
    end else begin
      dl_eff = DLW'(cfg_i.delay_frames);
    end
  end

  // Drop a stale position left over from a register change.
  assign wf_eff = ({1'b0, wf_q} >= dl_eff) ? '0 : wf_q;
  assign ci_eff = ({1'b0, ci_q} >= ch_eff) ? '0 : ci_q;
  assign ci_inc = {1'b0, ci_eff} + 1'b1;
  assign wf_inc = {1'b0, wf_eff} + 1'b1;

  assign mid_addr_o   = ADDR_W'(wf_eff) * ADDR_W'(ch_eff) + ADDR_W'(ci_eff);
  assign mid_op_o     = is_seek ? fed_pkg::OP_CLEAR : fed_pkg::OP_SAMPLE;
  assign mid_sample_o = in_data_i.in_sample;
  assign mid_end_o    = in_data_i.stream_end;
  // A seek that does not clear has no effect at all: drop it here.
  assign mid_push_o   = accept && (!is_seek || cfg_i.clear_on_seek);

  always_comb begin
    wf_d = wf_q;
    ci_d = ci_q;
    if (accept) begin
      if (is_seek) begin
        if (cfg_i.clear_on_seek) begin
          wf_d = '0;
          ci_d = '0;
        end
      end else if (ci_inc >= ch_eff) begin
        ci_d = '0;
        wf_d = (wf_inc >= dl_eff) ? '0 : wf_inc[FW-1:0];
      end else begin
        ci_d = ci_inc[CW-1:0];
        wf_d = wf_eff;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wf_q <= '0;
      ci_q <= '0;
    end else begin
      wf_q <= wf_d;
      ci_q <= ci_d;
    end
  end

endmodule

// ===== hdl/fed_back.sv =====
// Back end: delay store, read-modify-write pipeline and clearing sequencer.
module fed_back #(
  parameter int unsigned MAX_DELAY_FRAMES = 4096,
  parameter int unsigned MAX_CHANNELS     = 2,
  localparam int unsigned DEPTH  = MAX_DELAY_FRAMES * MAX_CHANNELS,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  fed_pkg::cfg_t                       cfg_i,
  input  logic                                head_empty_i,
  input  fed_pkg::op_e                        head_op_i,
  input  logic [ADDR_W-1:0]                   head_addr_i,
  input  logic signed [fed_pkg::SAMPLE_W-1:0] head_sample_i,
  input  logic                                head_end_i,
  output logic                                head_pop_o,
  input  logic [fed_pkg::OUT_CNT_W-1:0]       out_count_i,
  output logic                                out_push_o,
  output fed_pkg::out_item_t                  out_item_o,
  output logic                                clearing_o
);

  localparam int unsigned SW = fed_pkg::SAMPLE_W;
  localparam int unsigned GW = fed_pkg::GAIN_W + 1;
  localparam int unsigned FB = fed_pkg::FRAC_BITS;
  localparam int unsigned AccW = 36;
  localparam logic signed [AccW-1:0] HalfLsb = AccW'(1 << (FB - 1));
  localparam logic signed [AccW-1:0] SatHi   = AccW'((1 << (SW - 1)) - 1);
  localparam logic signed [AccW-1:0] SatLo   = -AccW'(1 << (SW - 1));

  function automatic logic signed [SW-1:0] round_sat(input logic signed [AccW-1:0] s);
    logic signed [AccW-1:0] t;
    t = (s + HalfLsb) >>> FB;
    if (t > SatHi) begin
      return SatHi[SW-1:0];
    end else if (t < SatLo) begin
      return SatLo[SW-1:0];
    end
    return t[SW-1:0];
  endfunction

  fed_pkg::back_state_e state_q, state_d;
  logic [ADDR_W-1:0]    clr_cnt_q, clr_cnt_d;
  logic                 issue, clear_we, credit_ok;

  logic signed [SW-1:0] store [DEPTH];
  logic signed [SW-1:0] rdata_q;
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_waddr;
  logic signed [SW-1:0] mem_wdata;

  logic                 s1_v_q, s2_v_q, wb_v_q, wb_v_d;
  logic [ADDR_W-1:0]    s1_addr_q, s2_addr_q, wb_addr_q;
  logic signed [SW-1:0] s1_x_q, s2_store_q, s2_y_q, wb_data_q;
  logic                 s1_end_q, s2_end_q;

  logic [GW-1:0]          mix_g, fb_g;
  logic signed [GW:0]     mix_s, fb_s;
  logic signed [SW-1:0]   d_fwd;
  logic signed [SW:0]     diff;
  logic signed [SW+GW:0]  prod_wet;
  logic signed [SW+GW:0]  prod_fb;
  logic signed [AccW-1:0] base, sum_wet, sum_fb;

  // Results in flight plus those queued must leave room for one more.
  assign credit_ok = (32'(out_count_i) + 32'(s1_v_q) + 32'(s2_v_q)) < fed_pkg::OUT_DEPTH;
  assign clearing_o = (state_q == fed_pkg::BK_CLEAR);

  always_comb begin
    state_d    = state_q;
    clr_cnt_d  = clr_cnt_q;
    head_pop_o = 1'b0;
    issue      = 1'b0;
    clear_we   = 1'b0;
    case (state_q)
      fed_pkg::BK_CLEAR: begin
        clear_we  = 1'b1;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == ADDR_W'(DEPTH - 1)) begin
          clr_cnt_d = '0;
          state_d   = fed_pkg::BK_RUN;
        end
      end
      fed_pkg::BK_RUN: begin
        if (!head_empty_i) begin
          if (head_op_i == fed_pkg::OP_CLEAR) begin
            // Let writes in flight land before sweeping the store.
            if (!s1_v_q && !s2_v_q) begin
              head_pop_o = 1'b1;
              state_d    = fed_pkg::BK_CLEAR;
            end
          end else if (credit_ok) begin
            head_pop_o = 1'b1;
            issue      = 1'b1;
          end
        end
      end
      default: state_d = fed_pkg::BK_CLEAR;
    endcase
  end

  assign mem_we    = clear_we || s2_v_q;
  assign mem_waddr = clear_we ? clr_cnt_q : s2_addr_q;
  assign mem_wdata = clear_we ? '0 : s2_store_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store[mem_waddr] <= mem_wdata;
    end
    if (issue) begin
      rdata_q <= store[head_addr_i];
    end
  end

  // Forward the newest write to the same slot: the one still in stage two,
  // else the one that hit the store while this read was taken.
  always_comb begin
    if (s2_v_q && (s2_addr_q == s1_addr_q)) begin
      d_fwd = s2_store_q;
    end else if (wb_v_q && (wb_addr_q == s1_addr_q)) begin
      d_fwd = wb_data_q;
    end else begin
      d_fwd = rdata_q;
    end
  end

  assign mix_g = (cfg_i.mix_gain > fed_pkg::GAIN_W'(fed_pkg::UNITY)) ?
                 GW'(fed_pkg::UNITY) : {1'b0, cfg_i.mix_gain};
  assign fb_g  = (cfg_i.feedback_gain > fed_pkg::GAIN_W'(fed_pkg::UNITY)) ?
                 GW'(fed_pkg::UNITY) : {1'b0, cfg_i.feedback_gain};
  assign mix_s = signed'({1'b0, mix_g});
  assign fb_s  = signed'({1'b0, fb_g});

  // wet = x*unity + (d - x)*mix, store = x*unity + d*feedback
  assign diff     = {d_fwd[SW-1], d_fwd} - {s1_x_q[SW-1], s1_x_q};
  assign prod_wet = diff * mix_s;
  assign prod_fb  = d_fwd * fb_s;
  assign base     = {{(AccW - SW - FB){s1_x_q[SW-1]}}, s1_x_q, {FB{1'b0}}};
  assign sum_wet  = base + AccW'(prod_wet);
  assign sum_fb   = base + AccW'(prod_fb);

  assign wb_v_d = clear_we ? 1'b0 : (s2_v_q ? 1'b1 : wb_v_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= fed_pkg::BK_CLEAR;
      clr_cnt_q <= '0;
      s1_v_q    <= 1'b0;
      s2_v_q    <= 1'b0;
      wb_v_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      s1_v_q    <= issue;
      s2_v_q    <= s1_v_q;
      wb_v_q    <= wb_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_addr_q <= head_addr_i;
      s1_x_q    <= head_sample_i;
      s1_end_q  <= head_end_i;
    end
    if (s1_v_q) begin
      s2_addr_q  <= s1_addr_q;
      s2_store_q <= round_sat(sum_fb);
      s2_y_q     <= round_sat(sum_wet);
      s2_end_q   <= s1_end_q;
    end
    if (s2_v_q) begin
      wb_addr_q <= s2_addr_q;
      wb_data_q <= s2_store_q;
    end
  end

  assign out_push_o                = s2_v_q;
  assign out_item_o.out_sample     = s2_y_q;
  assign out_item_o.stream_end_res = s2_end_q;

endmodule

// ===== hdl/feedback_echo_delay_unit.sv =====
// Top level of the feedback echo delay unit.
//
//   port group        direction  beat accepted when
//   push/full/in_data  in        push && !full
//   empty/pop/out_data out       pop && !empty
//   APB psel..pready   cfg       psel && penable && pwrite (pready tied high)
//
// One audio sample per cycle sustained while no sweep runs and results are
// popped; a sample goes through the mid queue and stages one and two to the
// output queue. The rate is set by the single read-modify-write pass over
// the delay store, with the two writes still in flight forwarded into the
// multiply stage. After reset, and after every seek that clears, the store
// is swept one entry a cycle over all MAX_DELAY_FRAMES*MAX_CHANNELS entries
// (8192 at the defaults) with full held high. A stalled output fills the
// four-entry result queue, then the mid queue, then raises full.
module feedback_echo_delay_unit #(
  parameter int unsigned MAX_DELAY_FRAMES = 4096,
  parameter int unsigned MAX_CHANNELS     = 2
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  input  fed_pkg::in_item_t           in_data_i,
  output logic                        full,
  output logic                        empty,
  input  logic                        pop,
  output fed_pkg::out_item_t          out_data_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fed_pkg::APB_AW-1:0]  paddr,
  input  logic [fed_pkg::APB_DW-1:0]  pwdata,
  output logic [fed_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);

  localparam int unsigned DEPTH  = MAX_DELAY_FRAMES * MAX_CHANNELS;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned SW     = fed_pkg::SAMPLE_W;
  localparam int unsigned MID_W  = 1 + ADDR_W + SW + 1;
  localparam int unsigned OUT_W  = $bits(fed_pkg::out_item_t);

  fed_pkg::cfg_t        cfg;
  logic                 clearing;

  logic                 mid_push, mid_full, mid_empty, mid_pop;
  fed_pkg::op_e         mid_op;
  logic [ADDR_W-1:0]    mid_addr;
  logic signed [SW-1:0] mid_sample;
  logic                 mid_end;
  logic [MID_W-1:0]     mid_wdata, mid_rdata;

  fed_pkg::op_e         head_op;
  logic [ADDR_W-1:0]    head_addr;
  logic signed [SW-1:0] head_sample;
  logic                 head_end;

  logic                          res_push;
  fed_pkg::out_item_t            res_item;
  logic [OUT_W-1:0]              out_rdata;
  logic [fed_pkg::OUT_CNT_W-1:0] out_count;

  fed_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  fed_front #(
    .MAX_DELAY_FRAMES (MAX_DELAY_FRAMES),
    .MAX_CHANNELS     (MAX_CHANNELS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .push_i       (push),
    .in_data_i    (in_data_i),
    .full_o       (full),
    .hold_i       (clearing),
    .mid_full_i   (mid_full),
    .mid_push_o   (mid_push),
    .mid_op_o     (mid_op),
    .mid_addr_o   (mid_addr),
    .mid_sample_o (mid_sample),
    .mid_end_o    (mid_end)
  );

  assign mid_wdata = {mid_op, mid_addr, mid_sample, mid_end};

  fed_fifo #(
    .WIDTH (MID_W),
    .DEPTH (fed_pkg::MID_DEPTH)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .data_i  (mid_wdata),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .data_o  (mid_rdata),
    .empty_o (mid_empty),
    .count_o ()
  );

  assign head_op     = fed_pkg::op_e'(mid_rdata[MID_W-1]);
  assign head_addr   = mid_rdata[MID_W-2 -: ADDR_W];
  assign head_sample = mid_rdata[SW:1];
  assign head_end    = mid_rdata[0];

  fed_back #(
    .MAX_DELAY_FRAMES (MAX_DELAY_FRAMES),
    .MAX_CHANNELS     (MAX_CHANNELS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .head_empty_i  (mid_empty),
    .head_op_i     (head_op),
    .head_addr_i   (head_addr),
    .head_sample_i (head_sample),
    .head_end_i    (head_end),
    .head_pop_o    (mid_pop),
    .out_count_i   (out_count),
    .out_push_o    (res_push),
    .out_item_o    (res_item),
    .clearing_o    (clearing)
  );

  fed_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (fed_pkg::OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_item),
    .full_o  (),
    .pop_i   (pop),
    .data_o  (out_rdata),
    .empty_o (empty),
    .count_o (out_count)
  );

  assign out_data_o = fed_pkg::out_item_t'(out_rdata);

endmodule

// ===== tb/echo_checker.sv =====
// Stream checker for the feedback echo delay unit: mirrors config writes and predicts each beat.
module echo_checker #(
  parameter int unsigned MAX_DELAY_FRAMES = 4096,
  parameter int unsigned MAX_CHANNELS     = 2
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  input  logic                       full,
  input  fed_pkg::in_item_t          in_data,
  input  logic                       pop,
  input  logic                       empty,
  input  fed_pkg::out_item_t         out_data,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic                       pready,
  input  logic [fed_pkg::APB_AW-1:0] paddr,
  input  logic [fed_pkg::APB_DW-1:0] pwdata,
  output int                         fail_count,
  output int                         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STORE_DEPTH = MAX_DELAY_FRAMES * MAX_CHANNELS;

  fed_pkg::cfg_t                       cfg;
  logic signed [fed_pkg::SAMPLE_W-1:0] echo_mem [STORE_DEPTH];
  int unsigned                         frame_pos;
  int unsigned                         chan_pos;
  fed_pkg::out_item_t                  echo_due [$];

  task automatic report_mismatch(input string what);
    fail_count++;
    $display("%0t ns: mismatch: %s", $time, what);
  endtask

  function automatic void wipe_echo();
    foreach (echo_mem[i]) echo_mem[i] = '0;
    frame_pos = 0;
    chan_pos  = 0;
  endfunction

  // Round half up, drop the Q1.15 fraction, clamp to the sample range.
  function automatic logic signed [fed_pkg::SAMPLE_W-1:0] round_sat(input longint acc);
    longint r;
    r = (acc + 64'sd16384) >>> fed_pkg::FRAC_BITS;
    if (r > 64'sd32767) r = 64'sd32767;
    else if (r < -64'sd32768) r = -64'sd32768;
    return r[fed_pkg::SAMPLE_W-1:0];
  endfunction

  function automatic void echo_beat(input fed_pkg::in_item_t beat);
    int unsigned        ch;
    int unsigned        dl;
    int unsigned        slot;
    longint             unity_l;
    longint             mix_w;
    longint             fb_w;
    longint             x;
    longint             d;
    fed_pkg::out_item_t res;
    if (beat.cmd == fed_pkg::CMD_SEEK) begin
      if (cfg.clear_on_seek) wipe_echo();
      return;
    end
    ch = cfg.channel_count;
    if (ch == 0) ch = 1;
    if (ch > MAX_CHANNELS) ch = MAX_CHANNELS;
    dl = cfg.delay_frames;
    if (dl == 0) dl = 1;
    if (dl > MAX_DELAY_FRAMES) dl = MAX_DELAY_FRAMES;
    // drop a position left stale by a register change
    if (frame_pos >= dl) frame_pos = 0;
    if (chan_pos >= ch) chan_pos = 0;
    slot = frame_pos * ch + chan_pos;
    if (slot >= STORE_DEPTH) slot = 0;

    unity_l = longint'(fed_pkg::UNITY);
    mix_w   = (cfg.mix_gain > fed_pkg::UNITY) ? unity_l : longint'(cfg.mix_gain);
    fb_w    = (cfg.feedback_gain > fed_pkg::UNITY) ? unity_l : longint'(cfg.feedback_gain);
    x       = longint'($signed(beat.in_sample));
    d       = longint'(echo_mem[slot]);

    res.out_sample     = round_sat(x * (unity_l - mix_w) + d * mix_w);
    res.stream_end_res = beat.stream_end;
    echo_mem[slot]     = round_sat(x * unity_l + d * fb_w);

    chan_pos++;
    if (chan_pos >= ch) begin
      chan_pos = 0;
      frame_pos++;
      if (frame_pos >= dl) frame_pos = 0;
    end
    echo_due.push_back(res);
  endfunction

  always @(posedge clk_i) begin : watch
    fed_pkg::out_item_t want;
    if (!rst_ni) begin
      cfg.channel_count = fed_pkg::RST_CHANNEL_COUNT;
      cfg.delay_frames  = fed_pkg::RST_DELAY_FRAMES;
      cfg.feedback_gain = fed_pkg::RST_FEEDBACK_GAIN;
      cfg.mix_gain      = fed_pkg::RST_MIX_GAIN;
      cfg.clear_on_seek = fed_pkg::RST_CLEAR_ON_SEEK;
      wipe_echo();
      echo_due.delete();
      fail_count = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[fed_pkg::APB_AW-1:2])
          fed_pkg::REG_CHANNEL_COUNT: cfg.channel_count = pwdata[1:0];
          fed_pkg::REG_DELAY_FRAMES:  cfg.delay_frames  = pwdata[12:0];
          fed_pkg::REG_FEEDBACK_GAIN: cfg.feedback_gain = pwdata[fed_pkg::GAIN_W-1:0];
          fed_pkg::REG_MIX_GAIN:      cfg.mix_gain      = pwdata[fed_pkg::GAIN_W-1:0];
          fed_pkg::REG_CLEAR_ON_SEEK: cfg.clear_on_seek = pwdata[0];
          default: ;
        endcase
      end
      if (pop && !empty) begin
        if (echo_due.size() == 0) begin
          report_mismatch($sformatf("result beat %0d/%0b with nothing due",
                                    out_data.out_sample, out_data.stream_end_res));
        end else begin
          want = echo_due.pop_front();
          if (out_data.out_sample !== want.out_sample)
            report_mismatch($sformatf("out_sample %0d, want %0d",
                                      out_data.out_sample, want.out_sample));
          if (out_data.stream_end_res !== want.stream_end_res)
            report_mismatch($sformatf("stream_end_res %0b, want %0b",
                                      out_data.stream_end_res, want.stream_end_res));
        end
      end
      if (push && !full) echo_beat(in_data);
    end
    pending = echo_due.size();
  end

endmodule

// ===== tb/feedback_echo_delay_unit_tb.sv =====
// Stimulus, handshake timing and verdict for the feedback echo delay unit.
module feedback_echo_delay_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_DELAY_FRAMES = 4096;
  localparam int unsigned MAX_CHANNELS     = 2;
  localparam int          CLK_PERIOD       = 4;
  localparam int          SETTLE_CYCLES    = 8;
  localparam int          STALL_LIMIT      = 40000;
  localparam int          HOLD_CYCLES      = 300;
  localparam int          RAND_PHASES      = 12;
  localparam int          RAND_ITEMS       = 119;
  localparam int          PRESSURE_PHASE   = 1;
  localparam logic [2:0]  UNMAPPED_REG     = 3'd5;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       push;
  fed_pkg::in_item_t          in_data;
  logic                       full;
  logic                       empty;
  logic                       pop;
  fed_pkg::out_item_t         out_data;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [fed_pkg::APB_AW-1:0] paddr;
  logic [fed_pkg::APB_DW-1:0] pwdata;
  logic [fed_pkg::APB_DW-1:0] prdata;
  logic                       pready;

  int fail_count;
  int pending;
  int quiet_cycles;
  bit idle_on;
  bit hold_req;
  bit hold_done;

  feedback_echo_delay_unit #(
    .MAX_DELAY_FRAMES(MAX_DELAY_FRAMES),
    .MAX_CHANNELS    (MAX_CHANNELS)
  ) i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .in_data_i (in_data),
    .full      (full),
    .empty     (empty),
    .pop       (pop),
    .out_data_o(out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  echo_checker #(
    .MAX_DELAY_FRAMES(MAX_DELAY_FRAMES),
    .MAX_CHANNELS    (MAX_CHANNELS)
  ) i_echo_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .pop       (pop),
    .empty     (empty),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial clk_i = 1'b0;
  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: random pop gaps, plus one long hold-off to back the block up.
  initial begin
    int gap;
    pop       = 1'b0;
    hold_done = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        pop <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        gap = $urandom_range(1, 12);
        pop <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic send_beat(input logic cmd, input logic [fed_pkg::SAMPLE_W-1:0] value,
                           input logic se);
    fed_pkg::in_item_t beat;
    beat.cmd        = cmd;
    beat.in_sample  = value;
    beat.stream_end = se;
    @(negedge clk_i);
    push    <= 1'b1;
    in_data <= beat;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  task automatic hold_push(input int n);
    repeat (n) begin
      @(negedge clk_i);
      push <= 1'b0;
    end
  endtask

  // Drain all due results, let in-flight seeks finish, and wait out any clearing sweep.
  task automatic settle_idle();
    @(negedge clk_i);
    push <= 1'b0;
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    while (full) @(negedge clk_i);
  endtask

  task automatic apb_write(input logic [2:0] idx, input logic [fed_pkg::APB_DW-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_config(input int unsigned ch, input int unsigned dl,
                            input int unsigned fb, input int unsigned mix,
                            input int unsigned clr);
    settle_idle();
    apb_write(fed_pkg::REG_CHANNEL_COUNT, ch);
    apb_write(fed_pkg::REG_DELAY_FRAMES, dl);
    apb_write(fed_pkg::REG_FEEDBACK_GAIN, fb);
    apb_write(fed_pkg::REG_MIX_GAIN, mix);
    apb_write(fed_pkg::REG_CLEAR_ON_SEEK, clr);
  endtask

  function automatic int unsigned pick_gain();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return fed_pkg::UNITY;
      2:       return $urandom_range(fed_pkg::UNITY + 1, 65535);
      default: return $urandom_range(0, fed_pkg::UNITY);
    endcase
  endfunction

  function automatic logic [fed_pkg::SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 5))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'($urandom_range(0, 511) - 256);
      default: return 16'($urandom());
    endcase
  endfunction

  initial begin
    int unsigned ch;
    int unsigned dl;
    bit          gaps;
    rst_ni   = 1'b0;
    push     = 1'b0;
    in_data  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    idle_on  = 1'b0;
    hold_req = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset register values
    send_beat(fed_pkg::CMD_SAMPLE, 16'h7FFF, 1'b0);
    send_beat(fed_pkg::CMD_SAMPLE, 16'h8000, 1'b1);

    // fully wet, unity feedback, one-frame delay: drive both rails into saturation
    set_config(1, 1, fed_pkg::UNITY, fed_pkg::UNITY, 1);
    repeat (3) send_beat(fed_pkg::CMD_SAMPLE, 16'h7FFF, 1'b0);
    repeat (3) send_beat(fed_pkg::CMD_SAMPLE, 16'h8000, 1'b1);

    // dry only, stereo; a seek that must not clear
    set_config(2, 3, 0, 0, 0);
    send_beat(fed_pkg::CMD_SAMPLE, 16'h0001, 1'b0);
    send_beat(fed_pkg::CMD_SAMPLE, 16'hFFFF, 1'b1);
    send_beat(fed_pkg::CMD_SAMPLE, 16'h5555, 1'b0);
    send_beat(fed_pkg::CMD_SAMPLE, 16'hAAAA, 1'b1);
    send_beat(fed_pkg::CMD_SEEK, 16'h1234, 1'b1);
    send_beat(fed_pkg::CMD_SAMPLE, 16'h0000, 1'b0);

    // out-of-range settings clamp; the frame position left above is now stale
    set_config(3, 0, 16'hFFFF, 40000, 1);
    send_beat(fed_pkg::CMD_SAMPLE, 16'h4000, 1'b0);
    send_beat(fed_pkg::CMD_SAMPLE, 16'hC000, 1'b0);
    send_beat(fed_pkg::CMD_SAMPLE, 16'h7FFF, 1'b1);
    send_beat(fed_pkg::CMD_SEEK, 16'hFFFF, 1'b0);
    send_beat(fed_pkg::CMD_SAMPLE, 16'h0100, 1'b0);
    send_beat(fed_pkg::CMD_SAMPLE, 16'hFF00, 1'b1);

    set_config(0, 8191, 1, 32767, 1);
    apb_write(UNMAPPED_REG, '1);
    send_beat(fed_pkg::CMD_SAMPLE, 16'h2000, 1'b0);
    send_beat(fed_pkg::CMD_SAMPLE, 16'hE000, 1'b1);

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case ($urandom_range(0, 7))
        0:       ch = 0;
        1:       ch = 3;
        default: ch = $urandom_range(1, MAX_CHANNELS);
      endcase
      case ($urandom_range(0, 9))
        0:       dl = 0;
        1:       dl = MAX_DELAY_FRAMES;
        2:       dl = $urandom_range(MAX_DELAY_FRAMES + 1, 8191);
        default: dl = $urandom_range(1, 48);
      endcase
      set_config(ch, dl, pick_gain(), pick_gain(), $urandom_range(0, 1));
      // no idling in every fourth phase and in the closing one
      gaps = (ph != RAND_PHASES - 1) && (ph % 4 != 3);
      idle_on <= gaps;
      if (ph == PRESSURE_PHASE) hold_req <= 1'b1;
      repeat (RAND_ITEMS) begin
        if (gaps && $urandom_range(0, 5) == 0) hold_push($urandom_range(1, 12));
        if ($urandom_range(0, 49) == 0)
          send_beat(fed_pkg::CMD_SEEK, rand_sample(), $urandom_range(0, 1));
        else
          send_beat(fed_pkg::CMD_SAMPLE, rand_sample(), $urandom_range(0, 7) == 0);
      end
    end

    settle_idle();
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/fed_pkg.sv
hdl/fed_regs.sv
hdl/fed_fifo.sv
hdl/fed_front.sv
hdl/fed_back.sv
hdl/feedback_echo_delay_unit.sv
tb/echo_checker.sv
tb/feedback_echo_delay_unit_tb.sv
